### hw/rtl/tsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsl_pkg;

  // Field and register widths.
  localparam int POS_W      = 48;
  localparam int OFFSET_W   = 17;
  localparam int WAVE_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SHAPE_W    = 3;
  localparam int PHASE_W    = 16;
  localparam int CYC_LEN_W  = 32;
  localparam int DEPTH_W    = 16;
  localparam int NOISE_W    = 32;
  localparam int HOLD_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int CYCLE_W    = 32;
  localparam int QUOT_W     = 64;

  localparam int SINE_TABLE_BITS_DEF = 8;

  // Fixed point constants, Q1.15 unless noted.
  localparam int ONE_Q15   = 32768;
  localparam int HALF_LSB  = 16384;
  localparam int THREE_HALVES_Q15 = 98304;
  localparam int Q15_SHIFT = 15;

  // Sample-and-hold noise source: right-shifting Galois LFSR.
  localparam logic [NOISE_W-1:0] LFSR_MASK = 32'hA300_0000;
  localparam int LFSR_STEPS_PER_CYCLE = 4;
  localparam int LFSR_DRAW_STEPS      = 16;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Wave shape codes.
  localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_RAMP     = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd4;
  localparam logic [SHAPE_W-1:0] SHAPE_HOLD     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIPOLAR_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [CYC_LEN_W-1:0] CYCLE_LENGTH_RST = 32'd65536;
  localparam logic [DEPTH_W-1:0]   DEPTH_RST        = 16'd32768;
  localparam logic [NOISE_W-1:0]   SEED_RST         = 32'd1;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // One entry of the quarter-wave sine table: Taylor series to x^15 in Q30
  // with truncating products, rounded half up to Q1.15.
  function automatic logic [15:0] sine_entry(input int unsigned idx,
                                             input int unsigned tbits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        e;
    int                 k;
    x    = (PI_HALF_Q30 * 64'(idx)) >> tbits;
    term = x;
    sum  = signed'(x);
    for (k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      unique case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (k % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (unsigned'(sum) + 64'd16384) >> 15;
    if (e > 64'd32768) begin
      e = 64'd32768;
    end
    return e[15:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tsl_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, two quotient bits per cycle. The dividend register
// shifts out its top bits while quotient bits shift in at the bottom.
module tsl_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [tsl_pkg::QUOT_W-1:0]    dividend,
  input  wire logic [tsl_pkg::CYC_LEN_W-1:0] divisor,
  output tsl_pkg::div_stat_t                 stat,
  output logic      [tsl_pkg::QUOT_W-1:0]    quotient
);
  import tsl_pkg::*;

  localparam int RADIX_BITS = 2;
  localparam int ITERS      = QUOT_W / RADIX_BITS;
  localparam int CNT_W      = $clog2(ITERS);

  typedef struct packed {
    logic                 q;
    logic [CYC_LEN_W-1:0] rem;
  } step_t;

  function automatic step_t div_step(input logic [CYC_LEN_W-1:0] rem,
                                     input logic                 nbit,
                                     input logic [CYC_LEN_W-1:0] d);
    logic [CYC_LEN_W:0] trial;
    logic [CYC_LEN_W:0] diff;
    step_t              res;
    trial = {rem, nbit};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      res.q   = 1'b1;
      res.rem = diff[CYC_LEN_W-1:0];
    end else begin
      res.q   = 1'b0;
      res.rem = trial[CYC_LEN_W-1:0];
    end
    return res;
  endfunction

  logic [QUOT_W-1:0]    dq_r;
  logic [CYC_LEN_W-1:0] rem_r;
  logic [CYC_LEN_W-1:0] d_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  step_t                s1;
  step_t                s2;

  always_comb begin
    s1 = div_step(rem_r, dq_r[QUOT_W-1], d_r);
    s2 = div_step(s1.rem, dq_r[QUOT_W-2], d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ITERS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[QUOT_W-RADIX_BITS-1:0], s1.q, s2.q};
      rem_r <= s2.rem;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

`default_nettype wire

### hw/rtl/tsl_lfsr.sv
`timescale 1ns / 1ps
`default_nettype none

// Noise register for sample-and-hold. Advances several LFSR steps per
// enabled cycle; a seed load replaces the state, with zero taken as one.
module tsl_lfsr (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        seed_load,
  input  wire logic [tsl_pkg::NOISE_W-1:0] seed,
  input  wire logic                        step_en,
  output logic      [tsl_pkg::NOISE_W-1:0] noise
);
  import tsl_pkg::*;

  logic [NOISE_W-1:0] noise_r;
  logic [NOISE_W-1:0] noise_nxt;
  logic [NOISE_W-1:0] stepped;

  always_comb begin
    stepped = noise_r;
    for (int i = 0; i < LFSR_STEPS_PER_CYCLE; i++) begin
      if (stepped[0]) begin
        stepped = (stepped >> 1) ^ LFSR_MASK;
      end else begin
        stepped = stepped >> 1;
      end
    end
  end

  always_comb begin
    noise_nxt = noise_r;
    if (seed_load) begin
      noise_nxt = (seed == '0) ? SEED_RST : seed;
    end else if (step_en) begin
      noise_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= SEED_RST;
    end else begin
      noise_r <= noise_nxt;
    end
  end

  assign noise = noise_r;

endmodule

`default_nettype wire

### hw/rtl/tsl_shaper.sv
`timescale 1ns / 1ps
`default_nettype none

// Turns the cycle fraction into a wave value in Q1.15. The sine comes from
// a quarter-wave table built at elaboration, mirrored by quadrant.
module tsl_shaper #(
  parameter int SINE_TABLE_BITS = tsl_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic        [tsl_pkg::SHAPE_W-1:0] shape,
  input  wire logic        [tsl_pkg::FRAC_W-1:0]  frac,
  input  wire logic signed [tsl_pkg::HOLD_W-1:0]  held,
  input  wire logic                               zero,
  output logic signed      [tsl_pkg::WAVE_W-1:0]  wave
);
  import tsl_pkg::*;

  localparam int N     = 1 << SINE_TABLE_BITS;
  localparam int IDX_W = SINE_TABLE_BITS + 1;
  localparam int EXT_W = WAVE_W + 1;

  logic [15:0] sine_rom [0:N];

  for (genvar g = 0; g <= N; g++) begin : g_sine
    localparam logic [15:0] ENTRY = sine_entry(g, SINE_TABLE_BITS);
    assign sine_rom[g] = ENTRY;
  end

  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [IDX_W-1:0]           idx;
  logic signed [WAVE_W-1:0]   sine_mag;
  logic signed [WAVE_W-1:0]   sine_v;
  logic signed [EXT_W-1:0]    tri_v;
  logic signed [EXT_W-1:0]    saw_v;
  logic signed [EXT_W-1:0]    ramp_v;
  logic signed [EXT_W-1:0]    frac_x;
  logic signed [EXT_W-1:0]    frac_x2;

  assign quad = frac[FRAC_W-1 -: 2];
  assign k    = frac[FRAC_W-3 -: SINE_TABLE_BITS];
  assign idx  = quad[0] ? (IDX_W'(N) - {1'b0, k}) : {1'b0, k};

  assign sine_mag = $signed({1'b0, sine_rom[idx]});
  assign sine_v   = quad[1] ? -sine_mag : sine_mag;

  assign frac_x  = $signed({2'b00, frac});
  assign frac_x2 = $signed({1'b0, frac, 1'b0});
  assign tri_v   = frac[FRAC_W-1] ? (EXT_W'(THREE_HALVES_Q15) - frac_x2)
                                  : (frac_x2 - EXT_W'(ONE_Q15));
  assign saw_v   = frac_x - EXT_W'(ONE_Q15);
  assign ramp_v  = EXT_W'(ONE_Q15) - frac_x;

  always_comb begin
    wave = '0;
    if (!zero) begin
      unique case (shape)
        SHAPE_SINE:     wave = sine_v;
        SHAPE_TRIANGLE: wave = tri_v[WAVE_W-1:0];
        SHAPE_SAW:      wave = saw_v[WAVE_W-1:0];
        SHAPE_RAMP:     wave = ramp_v[WAVE_W-1:0];
        SHAPE_SQUARE:   wave = frac[FRAC_W-1] ? WAVE_W'(-ONE_Q15) : WAVE_W'(ONE_Q15);
        SHAPE_HOLD:     wave = WAVE_W'(held);
        default:        wave = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tempo_synced_lfo_core.sv
// Tempo-synced LFO with sample-and-hold.
// Input channel: in_valid / in_stall carry in_position, the musical position
// in quarter notes (unsigned Q32.16). A transaction is taken when in_valid is
// high and in_stall is low. Output channel: out_valid / out_stall carry
// out_offset, the depth-scaled value in signed Q2.15, one per input.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_wdata; writes
// are always accepted and belong in idle periods. Writing the seed reloads the
// noise register.
// Timing: the position is divided by the cycle length in a radix-4 restoring
// divider of 32 iterations that then reports done. The sequencer then steps
// through phase, check, an optional noise draw for sample-and-hold, shape,
// multiply and round (a zero cycle length skips straight to shape); the next
// input can be taken in the cycle after the result is registered.
// The output register frees the input side: a new transaction is taken while
// a result still waits under out_stall; the block only holds its finished
// value back when the previous result has not yet been taken.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// hold state, seeds the noise register with one and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module tempo_synced_lfo_core #(
  parameter int SINE_TABLE_BITS = tsl_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tsl_pkg::POS_W-1:0]      in_position,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [tsl_pkg::OFFSET_W-1:0] out_offset,
  // Configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tsl_pkg::*;

  localparam int PROD_W = WAVE_W + DEPTH_W + 1;
  localparam int RND_W  = PROD_W + 1;
  localparam int P_W    = CYCLE_W + FRAC_W;
  localparam int NCNT_W = $clog2(LFSR_DRAW_STEPS / LFSR_STEPS_PER_CYCLE);
  localparam int NCNT_LAST = LFSR_DRAW_STEPS / LFSR_STEPS_PER_CYCLE - 1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_PHASE = 8'b0000_0100,
    ST_CHECK = 8'b0000_1000,
    ST_NOISE = 8'b0001_0000,
    ST_SHAPE = 8'b0010_0000,
    ST_MUL   = 8'b0100_0000,
    ST_ROUND = 8'b1000_0000
  } state_t;

  // Configuration registers.
  logic [SHAPE_W-1:0]   wave_shape_r;
  logic [PHASE_W-1:0]   phase_offset_r;
  logic [CYC_LEN_W-1:0] cycle_length_r;
  logic                 bipolar_mode_r;
  logic [DEPTH_W-1:0]   depth_r;

  // Sequencer and datapath.
  state_t                    state_r;
  state_t                    state_nxt;
  logic                      zero_r;
  logic                      draw_r;
  logic [NCNT_W-1:0]         noise_cnt_r;
  logic [P_W-1:0]            p_r;
  logic signed [WAVE_W-1:0]  wave_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      out_valid_r;
  logic signed [OFFSET_W-1:0] out_offset_r;

  // Sample-and-hold state.
  logic [CYCLE_W-1:0]        hold_cycle_r;
  logic                      hold_valid_r;
  logic signed [HOLD_W-1:0]  held_r;

  logic                      in_accept;
  logic                      cfg_write;
  logic                      seed_load;
  logic                      div_start;
  div_stat_t                 div_stat;
  logic [QUOT_W-1:0]         div_q;
  logic [NOISE_W-1:0]        noise;
  logic                      need_draw;
  logic signed [HOLD_W-1:0]  fresh_held;
  logic signed [HOLD_W-1:0]  held_eff;
  logic signed [WAVE_W-1:0]  shp_wave;
  logic [WAVE_W:0]           uni_sum;
  logic signed [RND_W-1:0]   rnd;
  logic signed [RND_W-1:0]   rnd_sh;
  logic signed [OFFSET_W-1:0] sat_v;
  logic                      out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign seed_load = cfg_write && (cfg_index == REG_RANDOM_SEED);
  assign div_start = in_accept && (cycle_length_r != '0);
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration writes. Indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_shape_r   <= SHAPE_SINE;
      phase_offset_r <= '0;
      cycle_length_r <= CYCLE_LENGTH_RST;
      bipolar_mode_r <= 1'b1;
      depth_r        <= DEPTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WAVE_SHAPE:   wave_shape_r   <= cfg_wdata[SHAPE_W-1:0];
        REG_PHASE_OFFSET: phase_offset_r <= cfg_wdata[PHASE_W-1:0];
        REG_CYCLE_LENGTH: cycle_length_r <= cfg_wdata[CYC_LEN_W-1:0];
        REG_BIPOLAR_MODE: bipolar_mode_r <= cfg_wdata[0];
        REG_DEPTH:        depth_r        <= cfg_wdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // The position, as Q32.16 shifted up by 16, over the Q16.16 cycle length
  // gives the phase with 16 fraction bits.
  tsl_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({in_position, {FRAC_W{1'b0}}}),
    .divisor  (cycle_length_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  tsl_lfsr u_lfsr (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed_load (seed_load),
    .seed      (cfg_wdata[NOISE_W-1:0]),
    .step_en   (state_r == ST_NOISE),
    .noise     (noise)
  );

  // A new sample is drawn on the first hold transaction and whenever the
  // cycle number moves on.
  assign need_draw = (wave_shape_r == SHAPE_HOLD) &&
                     (!hold_valid_r || (p_r[P_W-1:FRAC_W] != hold_cycle_r));

  // Top half of the noise register minus one half of full scale.
  assign fresh_held = $signed({~noise[NOISE_W-1], noise[NOISE_W-2:NOISE_W-HOLD_W]});
  assign held_eff   = draw_r ? fresh_held : held_r;

  tsl_shaper #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_shaper (
    .shape (wave_shape_r),
    .frac  (p_r[FRAC_W-1:0]),
    .held  (held_eff),
    .zero  (zero_r),
    .wave  (shp_wave)
  );

  // Unipolar mapping: (v + 1) / 2, never negative so a plain shift works.
  assign uni_sum = unsigned'({shp_wave[WAVE_W-1], shp_wave}) + (WAVE_W + 1)'(ONE_Q15);

  // Depth scaling, rounded half up and clamped to plus or minus one.
  assign rnd    = {prod_r[PROD_W-1], prod_r} + RND_W'(HALF_LSB);
  assign rnd_sh = rnd >>> Q15_SHIFT;

  always_comb begin
    if (rnd_sh > RND_W'(ONE_Q15)) begin
      sat_v = OFFSET_W'(ONE_Q15);
    end else if (rnd_sh < RND_W'(-ONE_Q15)) begin
      sat_v = OFFSET_W'(-ONE_Q15);
    end else begin
      sat_v = rnd_sh[OFFSET_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (cycle_length_r != '0) ? ST_DIV : ST_SHAPE;
        end
      end
      ST_DIV:   if (div_stat.done) state_nxt = ST_PHASE;
      ST_PHASE: state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = need_draw ? ST_NOISE : ST_SHAPE;
      ST_NOISE: if (noise_cnt_r == NCNT_W'(NCNT_LAST)) state_nxt = ST_SHAPE;
      ST_SHAPE: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ROUND;
      ST_ROUND: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control and hold state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      zero_r       <= 1'b0;
      draw_r       <= 1'b0;
      noise_cnt_r  <= '0;
      hold_cycle_r <= '0;
      hold_valid_r <= 1'b0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        zero_r <= (cycle_length_r == '0);
        draw_r <= 1'b0;
      end
      if ((state_r == ST_CHECK) && need_draw) begin
        hold_cycle_r <= p_r[P_W-1:FRAC_W];
        hold_valid_r <= 1'b1;
        draw_r       <= 1'b1;
        noise_cnt_r  <= '0;
      end
      if (state_r == ST_NOISE) begin
        noise_cnt_r <= noise_cnt_r + 1'b1;
      end
      if ((state_r == ST_SHAPE) && draw_r) begin
        held_r <= fresh_held;
      end
      if ((state_r == ST_ROUND) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_PHASE) begin
      p_r <= div_q[P_W-1:0] + P_W'(phase_offset_r);
    end
    if (state_r == ST_SHAPE) begin
      wave_r <= bipolar_mode_r ? shp_wave : $signed(uni_sum[WAVE_W:1]);
    end
    if (state_r == ST_MUL) begin
      prod_r <= wave_r * $signed({1'b0, depth_r});
    end
    if ((state_r == ST_ROUND) && out_free) begin
      out_offset_r <= sat_v;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_offset = out_offset_r;

  // The divider reports completion only to a sequencer that waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // While waiting on the divider it must be running or just finished.
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("divide state with an idle divider");

  // A result appears only out of the rounding step.
  a_out_from_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_ROUND))
    else $error("result raised without a rounding step");

  // Saturation keeps every result within plus or minus one.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_offset_r <= OFFSET_W'(ONE_Q15)) &&
                     (out_offset_r >= OFFSET_W'(-ONE_Q15))))
    else $error("result outside the saturated range");

  // A draw always records its cycle, and the LFSR never locks up at zero.
  a_noise_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NOISE) |-> (hold_valid_r && draw_r && (noise != '0)))
    else $error("noise draw without hold bookkeeping or with a dead LFSR");

endmodule

`default_nettype wire
